// ===== hdl/tpp_pkg.sv =====
// ---------------------------------------------------------------------------
// tpp_pkg
// Shared types and constants for the tank process plant step block.
// ---------------------------------------------------------------------------
package tpp_pkg;

    // value and gain formats
    localparam int VALUE_W    = 16;             // unsigned Q8.8
    localparam int GAIN_W     = 16;             // unsigned Q0.16

    // configuration port
    localparam int NUM_REGS   = 8;
    localparam int CFG_IDX_W  = $clog2(NUM_REGS);
    localparam int CFG_DATA_W = 16;

    // shared multiplier: magnitude operand is one bit wider than a value
    localparam int MUL_A_W    = VALUE_W + 1;
    localparam int MUL_B_W    = 16;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;

    // divide by ten as multiply by reciprocal, exact for operands below 81920
    localparam logic [MUL_B_W-1:0] RECIP_TEN      = 16'd52429;
    localparam int                 RECIP_TEN_SHR  = 19;
    localparam int                 STEP_W         = PROD_W - RECIP_TEN_SHR;
    localparam logic [MUL_A_W-1:0] STEP_ROUND     = 17'd5;

    // pressure target per unit of flow, 0.9 in Q0.16
    localparam logic [MUL_B_W-1:0] PRESS_PER_FLOW = 16'd58982;
    localparam int                 PRESS_SHR      = 16;

    // rounding biases
    localparam logic [PROD_W-1:0]  GAIN_HALF  = PROD_W'(64'd1 << (GAIN_W - 1));
    localparam logic [PROD_W-1:0]  PRESS_HALF = PROD_W'(64'd1 << (PRESS_SHR - 1));

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_INFLOW     = 3'd0,
        REG_OUTFLOW_RATE   = 3'd1,
        REG_TANK_CAPACITY  = 3'd2,
        REG_HIGH_LEVEL     = 3'd3,
        REG_LOW_LEVEL      = 3'd4,
        REG_HIGH_PRESSURE  = 3'd5,
        REG_FLOW_GAIN      = 3'd6,
        REG_PRESSURE_GAIN  = 3'd7
    } t_reg_idx;

    // reset values of the registers
    localparam logic [VALUE_W-1:0] RST_MAX_INFLOW    = 16'd3072;
    localparam logic [VALUE_W-1:0] RST_OUTFLOW_RATE  = 16'd1024;
    localparam logic [VALUE_W-1:0] RST_TANK_CAPACITY = 16'd25600;
    localparam logic [VALUE_W-1:0] RST_HIGH_LEVEL    = 16'd23040;
    localparam logic [VALUE_W-1:0] RST_LOW_LEVEL     = 16'd2560;
    localparam logic [VALUE_W-1:0] RST_HIGH_PRESSURE = 16'd2560;
    localparam logic [GAIN_W-1:0]  RST_FLOW_GAIN     = 16'd4369;
    localparam logic [GAIN_W-1:0]  RST_PRESSURE_GAIN = 16'd8192;

    // register file contents as seen by the datapath
    typedef struct packed {
        logic [VALUE_W-1:0] max_inflow;
        logic [VALUE_W-1:0] outflow_rate;
        logic [VALUE_W-1:0] tank_capacity;
        logic [VALUE_W-1:0] high_level_limit;
        logic [VALUE_W-1:0] low_level_limit;
        logic [VALUE_W-1:0] high_pressure_limit;
        logic [GAIN_W-1:0]  flow_lag_gain;
        logic [GAIN_W-1:0]  pressure_lag_gain;
    } t_cfg;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FLOW_MUL,
        S_FLOW_UPD,
        S_STEP_MUL,
        S_LEVEL_UPD,
        S_PT_MUL,
        S_PT_RND,
        S_PR_MUL,
        S_PR_UPD,
        S_DONE
    } t_state;

endpackage

// ===== hdl/tpp_in_if.sv =====
// ---------------------------------------------------------------------------
// tpp_in_if
// Input channel: one plant tick with the pump state.
// ---------------------------------------------------------------------------
interface tpp_in_if;
    logic valid;
    logic ready;
    logic pump_on;

    modport source (output valid, output pump_on, input ready);
    modport sink   (input valid, input pump_on, output ready);
endinterface

// ===== hdl/tpp_out_if.sv =====
// ---------------------------------------------------------------------------
// tpp_out_if
// Result channel: plant values and alarm flags after one tick.
// ---------------------------------------------------------------------------
interface tpp_out_if;
    logic                       valid;
    logic                       ready;
    logic [tpp_pkg::VALUE_W-1:0] level_out;
    logic [tpp_pkg::VALUE_W-1:0] flow_out;
    logic [tpp_pkg::VALUE_W-1:0] pressure_out;
    logic                       level_changed;
    logic                       alarm_high_level;
    logic                       alarm_low_level;
    logic                       alarm_high_pressure;

    modport source (
        output valid, output level_out, output flow_out, output pressure_out,
        output level_changed, output alarm_high_level, output alarm_low_level,
        output alarm_high_pressure, input ready
    );
    modport sink (
        input valid, input level_out, input flow_out, input pressure_out,
        input level_changed, input alarm_high_level, input alarm_low_level,
        input alarm_high_pressure, output ready
    );
endinterface

// ===== hdl/tank_process_plant_step_top.sv =====
// ---------------------------------------------------------------------------
// tank_process_plant_step_top
// One 100 ms tick of a tank plant: flow lag, level integration, pressure lag.
// ---------------------------------------------------------------------------
// Usage:
//   i_in carries one beat per plant tick (pump_on). o_out returns exactly one
//   beat per tick: level, flow, pressure (unsigned Q8.8), a level-changed
//   flag and the high-level, low-level and high-pressure alarms.
//   The configuration port writes register i_cfg_idx with i_cfg_data on any
//   edge with i_cfg_we high; write only while no tick is in flight.
// Datapath:
//   A single 17x16 multiplier is shared by the four products of a tick
//   (flow lag, divide by ten, pressure target, pressure lag), each followed
//   by a register and an update step, so no new input beat is taken until
//   the tick in flight has finished.
//   i_in.ready is high only while the sequencer is idle.
// Reset and stalls:
//   Synchronous reset clears flow, level and pressure to zero, loads the
//   register defaults and drops o_out.valid. A finished result sits in the
//   output register until taken; the next tick may be accepted and computed
//   meanwhile, and then waits in its last step until the register frees up.
// ---------------------------------------------------------------------------
module tank_process_plant_step_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tpp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tpp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    tpp_in_if.sink                          i_in,
    tpp_out_if.source                       o_out
);

    localparam int VW = tpp_pkg::VALUE_W;

    tpp_pkg::t_cfg   w_cfg;
    tpp_pkg::t_state r_state, n_state;

    // plant state and working registers
    logic [VW-1:0]              r_flow, r_level, r_press;
    logic                       r_pump;
    logic                       r_dir;
    logic [tpp_pkg::PROD_W-1:0] r_prod;
    logic [VW-1:0]              r_ptarget;
    logic                       r_lchg;

    // output register
    logic          r_out_valid;
    logic [VW-1:0] r_out_level, r_out_flow, r_out_press;
    logic          r_out_lchg, r_out_hi, r_out_lo, r_out_hp;

    // combinational datapath
    logic [VW-1:0]               l_flow_tgt, l_flow_d, l_out_d, l_press_d;
    logic                        l_flow_ge, l_out_ge, l_press_ge;
    logic [tpp_pkg::MUL_A_W-1:0] l_step_v, l_mul_a;
    logic [tpp_pkg::MUL_B_W-1:0] l_mul_b;
    logic [tpp_pkg::PROD_W-1:0]  l_prod, l_gain_rnd, l_pt_rnd;
    logic [VW-1:0]               l_mag, l_ptarget, l_lag_new;
    logic [VW-1:0]               l_step, l_lvl_dn, l_lvl_new;
    logic [VW:0]                 l_lvl_up;
    logic                        l_in_beat, l_out_beat, l_out_free;

    tpp_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // handshakes
    assign i_in.ready = (r_state == tpp_pkg::S_IDLE);
    assign l_in_beat  = i_in.valid && i_in.ready;
    assign l_out_beat = r_out_valid && o_out.ready;
    assign l_out_free = !r_out_valid || o_out.ready;

    // differences and directions
    always_comb begin
        l_flow_tgt = r_pump ? w_cfg.max_inflow : '0;
        l_flow_ge  = (l_flow_tgt >= r_flow);
        l_flow_d   = l_flow_ge ? (l_flow_tgt - r_flow) : (r_flow - l_flow_tgt);
        l_out_ge   = (r_flow >= w_cfg.outflow_rate);
        l_out_d    = l_out_ge ? (r_flow - w_cfg.outflow_rate)
                              : (w_cfg.outflow_rate - r_flow);
        l_step_v   = {1'b0, l_out_d} + tpp_pkg::STEP_ROUND;
        l_press_ge = (r_ptarget >= r_press);
        l_press_d  = l_press_ge ? (r_ptarget - r_press) : (r_press - r_ptarget);
    end

    // shared multiplier operand select
    always_comb begin
        l_mul_a = '0;
        l_mul_b = '0;
        case (r_state)
            tpp_pkg::S_FLOW_MUL: begin
                l_mul_a = {1'b0, l_flow_d};
                l_mul_b = w_cfg.flow_lag_gain;
            end
            tpp_pkg::S_STEP_MUL: begin
                l_mul_a = l_step_v;
                l_mul_b = tpp_pkg::RECIP_TEN;
            end
            tpp_pkg::S_PT_MUL: begin
                l_mul_a = {1'b0, r_flow};
                l_mul_b = tpp_pkg::PRESS_PER_FLOW;
            end
            tpp_pkg::S_PR_MUL: begin
                l_mul_a = {1'b0, l_press_d};
                l_mul_b = w_cfg.pressure_lag_gain;
            end
            default: ;
        endcase
        l_prod = tpp_pkg::PROD_W'(l_mul_a) * tpp_pkg::PROD_W'(l_mul_b);
    end

    // post-multiply rounding and updates
    always_comb begin
        l_gain_rnd = r_prod + tpp_pkg::GAIN_HALF;
        l_mag      = l_gain_rnd[tpp_pkg::GAIN_W +: VW];
        l_pt_rnd   = r_prod + tpp_pkg::PRESS_HALF;
        l_ptarget  = l_pt_rnd[tpp_pkg::PRESS_SHR +: VW];
        l_step     = VW'(r_prod[tpp_pkg::RECIP_TEN_SHR +: tpp_pkg::STEP_W]);
        // lag update for whichever value is in its update step
        if (r_state == tpp_pkg::S_FLOW_UPD) begin
            l_lag_new = r_dir ? (r_flow + l_mag) : (r_flow - l_mag);
        end else begin
            l_lag_new = r_dir ? (r_press + l_mag) : (r_press - l_mag);
        end
        // level move, clamped to zero and capacity
        l_lvl_up = {1'b0, r_level} + {1'b0, l_step};
        l_lvl_dn = (l_step > r_level) ? '0 : (r_level - l_step);
        if (r_dir) begin
            l_lvl_new = (l_lvl_up > {1'b0, w_cfg.tank_capacity}) ?
                        w_cfg.tank_capacity : l_lvl_up[VW-1:0];
        end else begin
            l_lvl_new = (l_lvl_dn > w_cfg.tank_capacity) ?
                        w_cfg.tank_capacity : l_lvl_dn;
        end
    end

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tpp_pkg::S_IDLE:      if (l_in_beat) n_state = tpp_pkg::S_FLOW_MUL;
            tpp_pkg::S_FLOW_MUL:  n_state = tpp_pkg::S_FLOW_UPD;
            tpp_pkg::S_FLOW_UPD:  n_state = tpp_pkg::S_STEP_MUL;
            tpp_pkg::S_STEP_MUL:  n_state = tpp_pkg::S_LEVEL_UPD;
            tpp_pkg::S_LEVEL_UPD: n_state = tpp_pkg::S_PT_MUL;
            tpp_pkg::S_PT_MUL:    n_state = tpp_pkg::S_PT_RND;
            tpp_pkg::S_PT_RND:    n_state = tpp_pkg::S_PR_MUL;
            tpp_pkg::S_PR_MUL:    n_state = tpp_pkg::S_PR_UPD;
            tpp_pkg::S_PR_UPD:    n_state = tpp_pkg::S_DONE;
            tpp_pkg::S_DONE:      if (l_out_free) n_state = tpp_pkg::S_IDLE;
            default:              n_state = tpp_pkg::S_IDLE;
        endcase
    end

    // plant state, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow  <= '0;
            r_level <= '0;
            r_press <= '0;
        end else begin
            if (r_state == tpp_pkg::S_FLOW_UPD) r_flow <= l_lag_new;
            if (r_state == tpp_pkg::S_PR_UPD)   r_press <= l_lag_new;
            if (r_state == tpp_pkg::S_LEVEL_UPD) r_level <= l_lvl_new;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (l_in_beat) r_pump <= i_in.pump_on;
        r_prod <= l_prod;
        case (r_state)
            tpp_pkg::S_FLOW_MUL:  r_dir <= l_flow_ge;
            tpp_pkg::S_STEP_MUL:  r_dir <= l_out_ge;
            tpp_pkg::S_PR_MUL:    r_dir <= l_press_ge;
            tpp_pkg::S_LEVEL_UPD: r_lchg <= (l_lvl_new != r_level);
            tpp_pkg::S_PT_RND:    r_ptarget <= l_ptarget;
            default: ;
        endcase
    end

    // output register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == tpp_pkg::S_DONE && l_out_free) begin
            r_out_valid <= 1'b1;
        end else if (l_out_beat) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register: payload with alarm compares
    always_ff @(posedge i_clk) begin
        if (r_state == tpp_pkg::S_DONE && l_out_free) begin
            r_out_level <= r_level;
            r_out_flow  <= r_flow;
            r_out_press <= r_press;
            r_out_lchg  <= r_lchg;
            r_out_hi    <= (r_level >= w_cfg.high_level_limit);
            r_out_lo    <= (r_level <= w_cfg.low_level_limit);
            r_out_hp    <= (r_press >= w_cfg.high_pressure_limit);
        end
    end

    assign o_out.valid               = r_out_valid;
    assign o_out.level_out           = r_out_level;
    assign o_out.flow_out            = r_out_flow;
    assign o_out.pressure_out        = r_out_press;
    assign o_out.level_changed       = r_out_lchg;
    assign o_out.alarm_high_level    = r_out_hi;
    assign o_out.alarm_low_level     = r_out_lo;
    assign o_out.alarm_high_pressure = r_out_hp;

    // an input beat always starts the flow step
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        l_in_beat |=> (r_state == tpp_pkg::S_FLOW_MUL))
        else $error("input beat did not start the sequencer");

    // a finished tick with a free output register is published and the block idles
    a_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tpp_pkg::S_DONE && l_out_free)
            |=> (r_out_valid && r_state == tpp_pkg::S_IDLE))
        else $error("finished tick not published");

    // a finished tick waits while the previous result is still stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tpp_pkg::S_DONE && r_out_valid && !o_out.ready)
            |=> (r_state == tpp_pkg::S_DONE && r_out_valid))
        else $error("pending result overwritten");

    // no input is taken while a tick is in flight
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != tpp_pkg::S_IDLE) |-> !i_in.ready)
        else $error("ready raised while busy");

endmodule

// ===== hdl/tpp_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// tpp_cfg_regs
// Configuration register file with write decode and reset values.
// ---------------------------------------------------------------------------
module tpp_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tpp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tpp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output tpp_pkg::t_cfg                      o_cfg
);

    tpp_pkg::t_cfg r_cfg;

    // register writes, decoded by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_inflow          <= tpp_pkg::RST_MAX_INFLOW;
            r_cfg.outflow_rate        <= tpp_pkg::RST_OUTFLOW_RATE;
            r_cfg.tank_capacity       <= tpp_pkg::RST_TANK_CAPACITY;
            r_cfg.high_level_limit    <= tpp_pkg::RST_HIGH_LEVEL;
            r_cfg.low_level_limit     <= tpp_pkg::RST_LOW_LEVEL;
            r_cfg.high_pressure_limit <= tpp_pkg::RST_HIGH_PRESSURE;
            r_cfg.flow_lag_gain       <= tpp_pkg::RST_FLOW_GAIN;
            r_cfg.pressure_lag_gain   <= tpp_pkg::RST_PRESSURE_GAIN;
        end else if (i_cfg_we) begin
            unique case (tpp_pkg::t_reg_idx'(i_cfg_idx))
                tpp_pkg::REG_MAX_INFLOW:    r_cfg.max_inflow          <= i_cfg_data;
                tpp_pkg::REG_OUTFLOW_RATE:  r_cfg.outflow_rate        <= i_cfg_data;
                tpp_pkg::REG_TANK_CAPACITY: r_cfg.tank_capacity       <= i_cfg_data;
                tpp_pkg::REG_HIGH_LEVEL:    r_cfg.high_level_limit    <= i_cfg_data;
                tpp_pkg::REG_LOW_LEVEL:     r_cfg.low_level_limit     <= i_cfg_data;
                tpp_pkg::REG_HIGH_PRESSURE: r_cfg.high_pressure_limit <= i_cfg_data;
                tpp_pkg::REG_FLOW_GAIN:     r_cfg.flow_lag_gain       <= i_cfg_data;
                tpp_pkg::REG_PRESSURE_GAIN: r_cfg.pressure_lag_gain   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== verif/tank_process_plant_step_check.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tank_process_plant_step_check
// Watches the config port and both channels of the tank plant step block,
// keeps its own copy of the plant state and register file, works out the
// reading that each accepted tick must produce and compares it field by
// field with the beats that leave the block, oldest first.
// ---------------------------------------------------------------------------
module tank_process_plant_step_check (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tpp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tpp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    tpp_in_if                               i_in,
    tpp_out_if                              i_out,
    output int                              o_errors,
    output int                              o_pending
);

    localparam int VW = tpp_pkg::VALUE_W;
    localparam int GW = tpp_pkg::GAIN_W;
    localparam int SW = VW + GW + 1;

    // 0.9 in Q0.16, pressure target per unit of flow
    localparam logic [15:0] PRESSURE_PER_FLOW = 16'd58982;

    typedef struct {
        logic [VW-1:0] level;
        logic [VW-1:0] flow;
        logic [VW-1:0] pressure;
        logic          level_changed;
        logic          alarm_high_level;
        logic          alarm_low_level;
        logic          alarm_high_pressure;
    } t_reading;

    tpp_pkg::t_cfg settings;
    logic [VW-1:0] flow_q;
    logic [VW-1:0] level_q;
    logic [VW-1:0] pressure_q;
    t_reading      expected_readings[$];
    int            err_count = 0;

    // first-order lag, step rounded half away from zero
    function automatic logic [VW-1:0] lag_toward(input logic [VW-1:0] cur,
                                                input logic [VW-1:0] target,
                                                input logic [GW-1:0] gain);
        logic [VW-1:0] span;
        logic [SW-1:0] scaled;
        logic [VW-1:0] moved;
        span   = (target >= cur) ? target - cur : cur - target;
        scaled = SW'(span) * SW'(gain) + SW'(1 << (GW - 1));
        moved  = VW'(scaled >> GW);
        return (target >= cur) ? cur + moved : cur - moved;
    endfunction

    // one plant tick: flow lag, level integration with clamp, pressure lag
    function automatic t_reading advance_plant(input logic pump);
        t_reading      r;
        logic [VW-1:0] level_before;
        logic [VW-1:0] press_target;
        logic [32:0]   press_scaled;
        int            flow_i;
        int            out_i;
        int            cap_i;
        int            lvl;
        level_before = level_q;
        flow_q = lag_toward(flow_q, pump ? settings.max_inflow : '0, settings.flow_lag_gain);
        flow_i = int'(flow_q);
        out_i  = int'(settings.outflow_rate);
        cap_i  = int'(settings.tank_capacity);
        lvl    = int'(level_before);
        if (flow_i >= out_i)
            lvl = lvl + (flow_i - out_i + 5) / 10;
        else
            lvl = lvl - (out_i - flow_i + 5) / 10;
        if (lvl < 0)
            lvl = 0;
        if (lvl > cap_i)
            lvl = cap_i;
        level_q = lvl[VW-1:0];

        press_scaled = 33'(flow_q) * 33'(PRESSURE_PER_FLOW) + 33'd32768;
        press_target = press_scaled[31:16];
        pressure_q   = lag_toward(pressure_q, press_target, settings.pressure_lag_gain);

        r.level               = level_q;
        r.flow                = flow_q;
        r.pressure            = pressure_q;
        r.level_changed       = (level_q != level_before);
        r.alarm_high_level    = (level_q >= settings.high_level_limit);
        r.alarm_low_level     = (level_q <= settings.low_level_limit);
        r.alarm_high_pressure = (pressure_q >= settings.high_pressure_limit);
        return r;
    endfunction

    function automatic int field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // register shadow, prediction and comparison
    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            settings.max_inflow          = 16'd3072;
            settings.outflow_rate        = 16'd1024;
            settings.tank_capacity       = 16'd25600;
            settings.high_level_limit    = 16'd23040;
            settings.low_level_limit     = 16'd2560;
            settings.high_pressure_limit = 16'd2560;
            settings.flow_lag_gain       = 16'd4369;
            settings.pressure_lag_gain   = 16'd8192;
            flow_q     = '0;
            level_q    = '0;
            pressure_q = '0;
            expected_readings.delete();
        end else begin
            if (i_cfg_we) begin
                case (tpp_pkg::t_reg_idx'(i_cfg_idx))
                    tpp_pkg::REG_MAX_INFLOW:    settings.max_inflow          = i_cfg_data;
                    tpp_pkg::REG_OUTFLOW_RATE:  settings.outflow_rate        = i_cfg_data;
                    tpp_pkg::REG_TANK_CAPACITY: settings.tank_capacity       = i_cfg_data;
                    tpp_pkg::REG_HIGH_LEVEL:    settings.high_level_limit    = i_cfg_data;
                    tpp_pkg::REG_LOW_LEVEL:     settings.low_level_limit     = i_cfg_data;
                    tpp_pkg::REG_HIGH_PRESSURE: settings.high_pressure_limit = i_cfg_data;
                    tpp_pkg::REG_FLOW_GAIN:     settings.flow_lag_gain       = i_cfg_data;
                    tpp_pkg::REG_PRESSURE_GAIN: settings.pressure_lag_gain   = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_in.valid && i_in.ready)
                expected_readings.push_back(advance_plant(i_in.pump_on));

            if (i_out.valid && i_out.ready) begin
                if (expected_readings.size() == 0) begin
                    $error("result beat with no tick waiting for it");
                    err_count++;
                end else begin
                    want = expected_readings.pop_front();
                    err_count += field_differs("level_out", 32'(want.level),
                                               32'(i_out.level_out));
                    err_count += field_differs("flow_out", 32'(want.flow),
                                               32'(i_out.flow_out));
                    err_count += field_differs("pressure_out", 32'(want.pressure),
                                               32'(i_out.pressure_out));
                    err_count += field_differs("level_changed", 32'(want.level_changed),
                                               32'(i_out.level_changed));
                    err_count += field_differs("alarm_high_level",
                                               32'(want.alarm_high_level),
                                               32'(i_out.alarm_high_level));
                    err_count += field_differs("alarm_low_level",
                                               32'(want.alarm_low_level),
                                               32'(i_out.alarm_low_level));
                    err_count += field_differs("alarm_high_pressure",
                                               32'(want.alarm_high_pressure),
                                               32'(i_out.alarm_high_pressure));
                end
            end
        end
        o_errors  <= err_count;
        o_pending <= expected_readings.size();
    end

endmodule

// ===== verif/tank_process_plant_step_top_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tank_process_plant_step_top_test
// Drives pump ticks into the tank plant step block in random bursts while the
// result side stalls on its own pattern. A short directed run covers reset
// values, full gains and flows, a capacity lowered under the level, frozen
// gains and alarm limits at the ends of the range; random register phases
// with short and long pump-on and pump-off runs follow. Checking is done
// beside the block by tank_process_plant_step_check.
// ---------------------------------------------------------------------------
module tank_process_plant_step_top_test;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_TICKS = 1600;
    localparam int DW           = tpp_pkg::CFG_DATA_W;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [tpp_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [DW-1:0]                  cfg_data;

    tpp_in_if  in_ch();
    tpp_out_if out_ch();

    int mismatches;
    int outstanding;

    logic [DW-1:0] plant_cfg [tpp_pkg::NUM_REGS];
    int hold_requests   = 0;
    int random_ticks    = 0;
    int settings_loaded = 0;
    int ticks_in        = 0;
    int pump_on_ticks   = 0;
    int results_seen    = 0;
    int idle_cycles     = 0;

    tank_process_plant_step_top uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    tank_process_plant_step_check u_check (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .o_errors   (mismatches),
        .o_pending  (outstanding)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // beat counters and watchdog on cycles without any progress
    always @(posedge clk) begin
        if (in_ch.valid && in_ch.ready) begin
            ticks_in <= ticks_in + 1;
            if (in_ch.pump_on)
                pump_on_ticks <= pump_on_ticks + 1;
        end
        if (out_ch.valid && out_ch.ready)
            results_seen <= results_seen + 1;
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $error("no beat moved for %0d cycles", STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // result side: stall modes change every so often, long hold on request
    initial begin : result_sink
        int mode;
        int left_in_mode;
        int hold_left;
        int hold_seen;
        out_ch.ready <= 1'b0;
        mode         = 0;
        left_in_mode = 0;
        hold_left    = 0;
        hold_seen    = 0;
        forever begin
            @(posedge clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (left_in_mode == 0) begin
                mode         = $urandom_range(0, 3);
                left_in_mode = $urandom_range(20, 200);
            end
            left_in_mode--;
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
                    2:       out_ch.ready <= ($urandom_range(0, 9) != 0);
                    default: out_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    task automatic load_plant_defaults();
        plant_cfg[tpp_pkg::REG_MAX_INFLOW]    = 16'd3072;
        plant_cfg[tpp_pkg::REG_OUTFLOW_RATE]  = 16'd1024;
        plant_cfg[tpp_pkg::REG_TANK_CAPACITY] = 16'd25600;
        plant_cfg[tpp_pkg::REG_HIGH_LEVEL]    = 16'd23040;
        plant_cfg[tpp_pkg::REG_LOW_LEVEL]     = 16'd2560;
        plant_cfg[tpp_pkg::REG_HIGH_PRESSURE] = 16'd2560;
        plant_cfg[tpp_pkg::REG_FLOW_GAIN]     = 16'd4369;
        plant_cfg[tpp_pkg::REG_PRESSURE_GAIN] = 16'd8192;
    endtask

    // writes the whole register file, one register per cycle
    task automatic write_settings();
        for (int r = 0; r < tpp_pkg::NUM_REGS; r++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= tpp_pkg::t_reg_idx'(r);
            cfg_data <= plant_cfg[r];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    // mostly plausible plant values, sometimes the ends of the range
    task automatic pick_settings();
        for (int r = 0; r < tpp_pkg::NUM_REGS; r++) begin
            case ($urandom_range(0, 9))
                0: plant_cfg[r] = '0;
                1: plant_cfg[r] = '1;
                2: plant_cfg[r] = DW'($urandom_range(0, 65535));
                default: begin
                    case (tpp_pkg::t_reg_idx'(r))
                        tpp_pkg::REG_MAX_INFLOW:
                            plant_cfg[r] = DW'($urandom_range(512, 8192));
                        tpp_pkg::REG_OUTFLOW_RATE:
                            plant_cfg[r] = DW'($urandom_range(0, 3072));
                        tpp_pkg::REG_TANK_CAPACITY:
                            plant_cfg[r] = DW'($urandom_range(4096, 40000));
                        tpp_pkg::REG_HIGH_LEVEL:
                            plant_cfg[r] = DW'($urandom_range(0, 40000));
                        tpp_pkg::REG_LOW_LEVEL:
                            plant_cfg[r] = DW'($urandom_range(0, 40000));
                        tpp_pkg::REG_HIGH_PRESSURE:
                            plant_cfg[r] = DW'($urandom_range(0, 6000));
                        default:
                            plant_cfg[r] = DW'($urandom_range(1000, 30000));
                    endcase
                end
            endcase
        end
    endtask

    // offers one tick and holds it until the block takes it
    task automatic send_tick(input logic pump);
        in_ch.valid   <= 1'b1;
        in_ch.pump_on <= pump;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // pump held on or off for runs of random length, sent in bursts
    task automatic run_ticks(input int count, input bit pause_midway);
        int   run_left;
        int   burst_left;
        int   gap;
        logic pump;
        run_left   = 0;
        burst_left = $urandom_range(1, 40);
        pump       = 1'b0;
        for (int k = 0; k < count; k++) begin
            if (run_left == 0) begin
                pump     = 1'($urandom_range(0, 1));
                run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                       : $urandom_range(10, 120);
            end
            send_tick(pump);
            run_left--;
            random_ticks++;
            burst_left--;
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
                if (gap > 0) begin
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 40);
            end
            if (pause_midway && k == count / 2)
                wait_drained();
        end
    endtask

    // stimulus and verdict
    initial begin : stimulus
        int phase;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_idx       <= '0;
        cfg_data      <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.pump_on <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, filling then draining
        repeat (5) send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        wait_drained();

        // full inflow, no outflow, full gains: level runs into capacity
        load_plant_defaults();
        plant_cfg[tpp_pkg::REG_MAX_INFLOW]    = '1;
        plant_cfg[tpp_pkg::REG_OUTFLOW_RATE]  = '0;
        plant_cfg[tpp_pkg::REG_FLOW_GAIN]     = '1;
        plant_cfg[tpp_pkg::REG_PRESSURE_GAIN] = '1;
        write_settings();
        repeat (4) send_tick(1'b1);
        wait_drained();

        // capacity lowered under the level, limits at the range ends
        plant_cfg[tpp_pkg::REG_TANK_CAPACITY] = 16'd1000;
        plant_cfg[tpp_pkg::REG_HIGH_LEVEL]    = '0;
        plant_cfg[tpp_pkg::REG_LOW_LEVEL]     = '1;
        plant_cfg[tpp_pkg::REG_HIGH_PRESSURE] = '0;
        write_settings();
        repeat (2) send_tick(1'b1);
        wait_drained();

        // zero gains freeze flow and pressure
        plant_cfg[tpp_pkg::REG_FLOW_GAIN]     = '0;
        plant_cfg[tpp_pkg::REG_PRESSURE_GAIN] = '0;
        write_settings();
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_drained();

        // full outflow with the pump off empties the tank
        plant_cfg[tpp_pkg::REG_OUTFLOW_RATE]  = '1;
        plant_cfg[tpp_pkg::REG_TANK_CAPACITY] = '1;
        plant_cfg[tpp_pkg::REG_HIGH_LEVEL]    = '1;
        plant_cfg[tpp_pkg::REG_LOW_LEVEL]     = '0;
        plant_cfg[tpp_pkg::REG_HIGH_PRESSURE] = '1;
        plant_cfg[tpp_pkg::REG_FLOW_GAIN]     = '1;
        plant_cfg[tpp_pkg::REG_PRESSURE_GAIN] = '1;
        write_settings();
        repeat (4) send_tick(1'b0);
        wait_drained();

        // random register phases
        phase = 0;
        while (random_ticks < RANDOM_TICKS) begin
            if (phase == 0)
                load_plant_defaults();
            else
                pick_settings();
            write_settings();
            if (phase % 4 == 1)
                hold_requests <= hold_requests + 1;
            run_ticks($urandom_range(120, 260), phase % 4 == 2);
            wait_drained();
            phase++;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d ticks sent (%0d with the pump running) over %0d register settings",
                 ticks_in, pump_on_ticks, settings_loaded);
        $display("%0d readings compared, %0d field mismatches", results_seen, mismatches);
        if (mismatches == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            if (outstanding != 0)
                $error("%0d readings never arrived", outstanding);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/tpp_pkg.sv
hdl/tpp_in_if.sv
hdl/tpp_out_if.sv
hdl/tpp_cfg_regs.sv
hdl/tank_process_plant_step_top.sv
verif/tank_process_plant_step_check.sv
verif/tank_process_plant_step_top_test.sv
